>>> src/prq_pkg.sv
package prq_pkg;

	localparam logic [3:0] FN_CREATE = 4'd0;
	localparam logic [3:0] FN_EXIT   = 4'd1;
	localparam logic [3:0] FN_YIELD  = 4'd2;
	localparam logic [3:0] FN_SLEEP  = 4'd3;
	localparam logic [3:0] FN_WAKE   = 4'd4;
	localparam logic [3:0] FN_GETID  = 4'd5;
	localparam logic [3:0] FN_CHPRIO = 4'd6;
	localparam logic [3:0] FN_FAULT  = 4'd7;
	localparam logic [3:0] FN_MEM    = 4'd8;

	localparam int FUNC_W = 4;
	localparam int PREQ_W = 5;
	localparam int TGT_W  = 3;
	localparam int RES_W  = 5;

	// thread ids and priorities are tied to the port widths above
	localparam int THREAD_SLOTS    = 8;
	localparam int PRIORITY_LEVELS = 16;

endpackage

>>> src/prq_lvl_mem.sv
// Per-level head/tail memory, one write port, one registered read port.
module prq_lvl_mem #(
	parameter int LEVELS = 16,
	parameter int TW     = 3
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [$clog2(LEVELS)-1:0] waddr,
	input  logic [TW-1:0]             whead,
	input  logic [TW-1:0]             wtail,
	input  logic [$clog2(LEVELS)-1:0] raddr,
	output logic [TW-1:0]             rhead,
	output logic [TW-1:0]             rtail
);
	logic [2*TW-1:0] mem [LEVELS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {whead, wtail};
		end
		{rhead, rtail} <= mem[raddr];
	end
endmodule

>>> src/priority_ready_queue_scheduler_core.sv
// Thread scheduler with one FIFO ready queue per priority level (level 0 most
// urgent). Each call is one item with exactly one result item. A call is run
// by a sequencer from accept to result valid: taking the caller off its queue
// and each re-queue read the level's head/tail entry from a registered memory
// and write it back; the free-slot and highest-level searches walk one entry
// per cycle. A new call is taken only after the previous result item has left.
// Once no thread is ready the block stays halted until reset and answers
// every call with halted set.
module priority_ready_queue_scheduler_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [prq_pkg::FUNC_W-1:0]             func,
	input  logic signed [prq_pkg::PREQ_W-1:0]      priority_req,
	input  logic [prq_pkg::TGT_W-1:0]              target_thread,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [prq_pkg::RES_W-1:0]       result_value,
	output logic                                   status,
	output logic [prq_pkg::TGT_W-1:0]              running_thread,
	output logic                                   halted
);
	localparam int THREAD_SLOTS    = prq_pkg::THREAD_SLOTS;
	localparam int PRIORITY_LEVELS = prq_pkg::PRIORITY_LEVELS;
	localparam int TW = $clog2(THREAD_SLOTS);
	localparam int LW = $clog2(PRIORITY_LEVELS);
	localparam int CW = $clog2(THREAD_SLOTS + PRIORITY_LEVELS + 1);
	localparam int TGT_W_FIX = prq_pkg::TGT_W;
	localparam int RES_W_FIX = prq_pkg::RES_W;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DQRD   = 4'd1;
	localparam logic [3:0] S_DQWR   = 4'd2;
	localparam logic [3:0] S_FIND   = 4'd3;
	localparam logic [3:0] S_OP     = 4'd4;
	localparam logic [3:0] S_ENQRD  = 4'd5;
	localparam logic [3:0] S_ENQWR  = 4'd6;
	localparam logic [3:0] S_SEL    = 4'd7;
	localparam logic [3:0] S_SELRD  = 4'd8;
	localparam logic [3:0] S_SELWT  = 4'd9;
	localparam logic [3:0] S_OUT    = 4'd10;

	logic [3:0]                 state_q;
	logic [THREAD_SLOTS-1:0]    used_q, ready_q;
	logic [LW-1:0]              prio_q [THREAD_SLOTS];
	logic [TW-1:0]              next_q [THREAD_SLOTS];
	logic [PRIORITY_LEVELS-1:0] nonempty_q;
	logic [TW-1:0]              cur_q;
	logic                       curv_q, down_q;
	logic [3:0]                 func_q;
	logic                       pneg_q;
	logic [LW-1:0]              pclamp_q;
	logic [TGT_W_FIX-1:0]       tgt_q;
	logic [CW-1:0]              idx_q;
	// enqueue list: caller first, then second thread
	logic [TW-1:0]              enq_t_q [2];
	logic [1:0]                 enq_v_q;
	logic                       enq_sel_q;
	logic [RES_W_FIX-1:0]       res_q;
	logic                       st_q, halt_q, ov_q;
	logic [TGT_W_FIX-1:0]       run_q;

	logic                       mwe;
	logic [LW-1:0]              mwaddr, mraddr;
	logic [TW-1:0]              mwhead, mwtail, mrhead, mrtail;

	prq_lvl_mem #(.LEVELS(PRIORITY_LEVELS), .TW(TW)) u_lvl (
		.clk(clk), .we(mwe), .waddr(mwaddr), .whead(mwhead), .wtail(mwtail),
		.raddr(mraddr), .rhead(mrhead), .rtail(mrtail)
	);

	logic [TW-1:0] enq_t;
	logic [LW-1:0] enq_p, cur_p;
	assign enq_t = enq_t_q[enq_sel_q];
	assign enq_p = prio_q[enq_t];
	assign cur_p = prio_q[cur_q];

	always_comb begin
		mwe    = 1'b0;
		mwaddr = cur_p;
		mwhead = next_q[cur_q];
		mwtail = mrtail;
		mraddr = cur_p;
		unique case (state_q)
			S_DQWR: begin
				mwe = ready_q[cur_q] && (mrtail != cur_q);
			end
			S_ENQRD, S_ENQWR: begin
				mraddr = enq_p;
				mwaddr = enq_p;
				mwe    = (state_q == S_ENQWR) && !ready_q[enq_t];
				mwhead = nonempty_q[enq_p] ? mrhead : enq_t;
				mwtail = enq_t;
			end
			S_SEL, S_SELRD, S_SELWT: begin
				mraddr = idx_q[LW-1:0];
			end
			default: begin
			end
		endcase
	end

	logic [LW-1:0] in_clamp;
	always_comb begin
		if ({1'b0, priority_req[prq_pkg::PREQ_W-2:0]} >= (prq_pkg::PREQ_W)'(PRIORITY_LEVELS))
			in_clamp = LW'(PRIORITY_LEVELS - 1);
		else
			in_clamp = LW'(priority_req[prq_pkg::PREQ_W-2:0]);
	end

	assign in_ready       = (state_q == S_IDLE) && !ov_q;
	assign out_valid      = ov_q;
	assign result_value   = res_q;
	assign status         = st_q;
	assign running_thread = run_q;
	assign halted         = halt_q;

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid && in_ready) begin
			func_q   <= func;
			pneg_q   <= priority_req[prq_pkg::PREQ_W-1];
			pclamp_q <= in_clamp;
			tgt_q    <= target_thread;
		end
		if (state_q == S_ENQWR && !ready_q[enq_t] && nonempty_q[enq_p]) begin
			next_q[mrtail] <= enq_t;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			used_q     <= '0;
			ready_q    <= '0;
			nonempty_q <= '0;
			for (int i = 0; i < THREAD_SLOTS; i++) begin
				prio_q[i] <= '0;
			end
			cur_q      <= '0;
			curv_q     <= 1'b0;
			down_q     <= 1'b0;
			idx_q      <= '0;
			enq_v_q    <= '0;
			enq_sel_q  <= 1'b0;
			enq_t_q[0] <= '0;
			enq_t_q[1] <= '0;
			res_q      <= '0;
			st_q       <= 1'b0;
			halt_q     <= 1'b0;
			run_q      <= '0;
			ov_q       <= 1'b0;
		end else begin
			if (ov_q && out_ready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						res_q   <= '0;
						st_q    <= 1'b0;
						enq_v_q <= '0;
						enq_sel_q <= 1'b0;
						idx_q   <= '0;
						if (down_q) begin
							halt_q <= 1'b1;
							run_q  <= '0;
							ov_q   <= 1'b1;
						end else if (curv_q && ready_q[cur_q]) begin
							state_q <= S_DQRD;
						end else begin
							state_q <= (func == prq_pkg::FN_CREATE) ? S_FIND : S_OP;
						end
					end
				end
				S_DQRD: state_q <= S_DQWR;
				S_DQWR: begin
					if (mrtail == cur_q) begin
						nonempty_q[cur_p] <= 1'b0;
					end
					ready_q[cur_q] <= 1'b0;
					state_q <= (func_q == prq_pkg::FN_CREATE) ? S_FIND : S_OP;
				end
				S_FIND: begin
					// walk for the lowest free slot
					if (idx_q == CW'(THREAD_SLOTS)) begin
						res_q   <= '1;
						st_q    <= 1'b1;
						enq_t_q[0] <= cur_q;
						enq_v_q <= {1'b0, curv_q};
						state_q <= S_ENQRD;
					end else if (!used_q[idx_q[TW-1:0]]) begin
						used_q[idx_q[TW-1:0]]  <= 1'b1;
						ready_q[idx_q[TW-1:0]] <= 1'b0;
						prio_q[idx_q[TW-1:0]]  <= pneg_q ? '0 : pclamp_q;
						res_q      <= RES_W_FIX'(idx_q);
						enq_t_q[0] <= cur_q;
						enq_t_q[1] <= idx_q[TW-1:0];
						enq_v_q    <= {1'b1, curv_q};
						cur_q      <= idx_q[TW-1:0];
						curv_q     <= 1'b1;
						state_q    <= S_ENQRD;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_OP: begin
					enq_t_q[0] <= cur_q;
					enq_t_q[1] <= tgt_q[TW-1:0];
					if (curv_q) begin
						unique case (func_q)
							prq_pkg::FN_EXIT, prq_pkg::FN_FAULT: begin
								used_q[cur_q]  <= 1'b0;
								prio_q[cur_q]  <= '0;
								ready_q[cur_q] <= 1'b0;
							end
							prq_pkg::FN_YIELD, prq_pkg::FN_MEM: enq_v_q <= 2'b01;
							prq_pkg::FN_WAKE: begin
								enq_v_q <= {(32'(tgt_q) < THREAD_SLOTS) &&
									used_q[tgt_q[TW-1:0]], 1'b1};
							end
							prq_pkg::FN_GETID: begin
								enq_v_q <= 2'b01;
								res_q   <= RES_W_FIX'(cur_q);
							end
							prq_pkg::FN_CHPRIO: begin
								enq_v_q <= 2'b01;
								res_q   <= RES_W_FIX'(cur_p);
								if (!pneg_q) prio_q[cur_q] <= pclamp_q;
							end
							default: begin
							end
						endcase
					end
					state_q <= S_ENQRD;
				end
				S_ENQRD: begin
					if (!enq_v_q[enq_sel_q]) begin
						if (enq_sel_q) begin
							idx_q   <= '0;
							state_q <= S_SEL;
						end
						enq_sel_q <= 1'b1;
					end else begin
						state_q <= S_ENQWR;
					end
				end
				S_ENQWR: begin
					if (!ready_q[enq_t]) begin
						nonempty_q[enq_p] <= 1'b1;
						ready_q[enq_t]    <= 1'b1;
					end
					enq_sel_q <= 1'b1;
					if (enq_sel_q) begin
						idx_q   <= '0;
						state_q <= S_SEL;
					end else begin
						state_q <= S_ENQRD;
					end
				end
				S_SEL: begin
					// scan levels, most urgent first
					if (idx_q == CW'(PRIORITY_LEVELS)) begin
						down_q  <= 1'b1;
						halt_q  <= 1'b1;
						run_q   <= '0;
						ov_q    <= 1'b1;
						state_q <= S_IDLE;
					end else if (nonempty_q[idx_q[LW-1:0]]) begin
						state_q <= S_SELRD;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_SELRD: state_q <= S_SELWT;
				S_SELWT: begin
					cur_q   <= mrhead;
					curv_q  <= 1'b1;
					halt_q  <= 1'b0;
					run_q   <= TGT_W_FIX'(mrhead);
					state_q <= S_OUT;
				end
				S_OUT: begin
					ov_q    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
